>>> sv/pps_pkg.sv
// pps_pkg: shared types and constants for the prime sieve block
// payload structs, sequencer states and remainder unit status
// no dependencies
`default_nettype none

package pps_pkg;

    localparam int unsigned FIELD_BITS = 16;

    typedef struct packed {
        logic [FIELD_BITS-1:0] candidate;
        logic                  last;
    } item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] prime_value;
        logic                  table_full;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_DIV,
        ST_EMIT,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

`default_nettype wire

>>> sv/pps_rem.sv
// pps_rem: iterative restoring remainder unit, one quotient bit per cycle
// depends on pps_pkg for the status struct
`default_nettype none

module pps_rem #(
    parameter int unsigned W = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [W-1:0]       dividend,
    input  wire logic [W-1:0]       divisor,
    output logic [W-1:0]            remainder,
    output pps_pkg::rem_status_t    status
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[W-1:0];
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished iteration");

endmodule

`default_nettype wire

>>> sv/pipelined_prime_sieve.sv
// pipelined_prime_sieve: top level, sequencer, divisor table and result register
// depends on pps_pkg and pps_rem
//
//   channel  valid         stall         payload              dir
//   item     item_valid    item_stall    pps_pkg::item_t      in
//   result   result_valid  result_stall  pps_pkg::result_t    out
//
// the shared remainder unit resolves one quotient bit per cycle
// reset clears state, divisor count, index and result valid; table entries stay undefined until written
// a result waits in the output register while the next transaction is taken
// a second survivor waits in the emit step until the output register drains
`default_nettype none

module pipelined_prime_sieve #(
    parameter int unsigned MAX_STAGES = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire pps_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output pps_pkg::result_t       result
);

    localparam int unsigned CNT_W = $clog2(MAX_STAGES + 1);
    localparam int unsigned IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    pps_pkg::seq_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic                  last_reg, last_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  result_valid_reg, result_valid_next;
    pps_pkg::result_t      result_reg, result_next;

    logic [VALUE_BITS-1:0] tbl_mem [MAX_STAGES];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  tbl_we;

    logic                  accept;
    logic                  rem_start;
    logic                  out_load;
    logic                  is_full;
    logic [VALUE_BITS-1:0] rem_value;
    pps_pkg::rem_status_t  rem_stat;

    pps_rem #(
        .W (VALUE_BITS)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (cand_reg),
        .divisor   (rd_data_reg),
        .remainder (rem_value),
        .status    (rem_stat)
    );

    assign accept  = item_valid && !item_stall;
    assign is_full = (count_reg == CNT_W'(MAX_STAGES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pps_pkg::ST_CHECK;
                end
            end
            pps_pkg::ST_CHECK:
            begin
                if (cand_reg == '0)
                begin
                    state_next = pps_pkg::ST_FINISH;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = pps_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = pps_pkg::ST_FETCH;
                end
            end
            pps_pkg::ST_FETCH:
            begin
                if (rd_data_reg == '0)
                begin
                    state_next = pps_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = pps_pkg::ST_DIV;
                end
            end
            pps_pkg::ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_value == '0)
                    begin
                        state_next = pps_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = pps_pkg::ST_CHECK;
                    end
                end
            end
            pps_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = pps_pkg::ST_FINISH;
                end
            end
            pps_pkg::ST_FINISH:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_stall = 1'b1;
        rem_start  = 1'b0;
        out_load   = 1'b0;
        tbl_we     = 1'b0;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            pps_pkg::ST_FETCH:
            begin
                rem_start = (rd_data_reg != '0);
            end
            pps_pkg::ST_EMIT:
            begin
                out_load = !result_valid_reg || !result_stall;
                tbl_we   = out_load && !is_full;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cand_next         = cand_reg;
        last_next         = last_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (accept)
        begin
            cand_next = VALUE_BITS'(item.candidate);
            last_next = item.last;
            idx_next  = '0;
        end
        if (state_reg == pps_pkg::ST_FETCH && rd_data_reg == '0)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (state_reg == pps_pkg::ST_DIV && rem_stat.done)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (out_load)
        begin
            result_next.prime_value = pps_pkg::FIELD_BITS'(cand_reg);
            result_next.table_full  = is_full;
            result_valid_next       = 1'b1;
        end
        if (tbl_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (state_reg == pps_pkg::ST_FINISH)
        begin
            idx_next = '0;
        end
        if (state_reg == pps_pkg::ST_FINISH && last_reg)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pps_pkg::ST_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        last_reg   <= last_next;
        result_reg <= result_next;
    end

    // divisor table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[count_reg[IDX_W-1:0]] <= cand_reg;
        end
        rd_data_reg <= tbl_mem[idx_reg[IDX_W-1:0]];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STAGES))
        else $error("divisor count beyond table depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("table index past divisor count");

    a_rem_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        rem_start |-> !rem_stat.busy)
        else $error("remainder unit started while busy");

    a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result_valid_reg)
        else $error("emitted result not held in output register");

endmodule

`default_nettype wire

>>> test/pps_checker.sv
// pps_checker: predicts the prime sieve results from the item stream and compares them
// watches both channels of pipelined_prime_sieve; depends on pps_pkg
// hands the mismatch count and the number of results still due to the testbench top

module pps_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_stall,
    input  wire pps_pkg::item_t   item,
    input  wire logic             result_valid,
    input  wire logic             result_stall,
    input  wire pps_pkg::result_t result,
    output int                    fails,
    output int                    pending
);

    localparam int DEPTH = 16;

    logic [pps_pkg::FIELD_BITS-1:0] divisors [DEPTH];
    int                             divisor_cnt = 0;
    pps_pkg::result_t               primes_due [$];
    int                             mismatches = 0;
    int                             due_count = 0;
    int                             results_seen = 0;

    assign fails   = mismatches;
    assign pending = due_count;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    task automatic sieve_candidate(input pps_pkg::item_t it);
        logic             survives;
        pps_pkg::result_t hit;
        survives = 1'b1;
        if (it.candidate != '0) begin
            for (int i = 0; i < divisor_cnt; i++)
                if (it.candidate % divisors[i] == '0)
                    survives = 1'b0;
            if (survives) begin
                hit.prime_value = it.candidate;
                hit.table_full  = (divisor_cnt >= DEPTH);
                if (divisor_cnt < DEPTH) begin
                    divisors[divisor_cnt] = it.candidate;
                    divisor_cnt++;
                end
                primes_due.push_back(hit);
            end
        end
        if (it.last)
            divisor_cnt = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pps_pkg::result_t due;
        if (!rst_n) begin
            divisor_cnt = 0;
            primes_due.delete();
        end else begin
            if (result_valid && !result_stall) begin
                if (primes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected prime %h full %b",
                                              result.prime_value, result.table_full));
                end else begin
                    due = primes_due.pop_front();
                    if (result.prime_value !== due.prime_value)
                        report_mismatch($sformatf("prime_value %h, expected %h",
                                                  result.prime_value, due.prime_value));
                    if (result.table_full !== due.table_full)
                        report_mismatch($sformatf("table_full %b, expected %b for %h",
                                                  result.table_full, due.table_full,
                                                  due.prime_value));
                end
                results_seen++;
            end
            if (item_valid && !item_stall)
                sieve_candidate(item);
        end
        due_count = primes_due.size();
    end

endmodule

>>> test/tb.sv
// tb: stimulus and verdict for pipelined_prime_sieve
// drives candidate streams with random gaps and stalls; depends on pps_pkg and pps_checker
// the checker instance predicts and compares, this module only reports the outcome

module tb;

    localparam int TOTAL        = 1950;
    localparam int CALM_FROM    = 1700;
    localparam int HOLD_CYCLES  = 500;
    localparam int WATCH_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 400;
    localparam int CAND_BITS    = pps_pkg::FIELD_BITS;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    pps_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    pps_pkg::result_t result;
    int               fails;
    int               pending;
    int               sent;
    int               idle_cycles;
    logic             calm;
    logic             hold_go;

    int unsigned first_primes [16] = '{2, 3, 5, 7, 11, 13, 17, 19,
                                      23, 29, 31, 37, 41, 43, 47, 53};

    pipelined_prime_sieve dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    pps_checker sieve_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fails        (fails),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCH_LIMIT) begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results due",
                 WATCH_LIMIT, pending);
        $display("** pipelined_prime_sieve: FAILED **");
        $finish;
    end

    // result side: random stall bursts, one long hold when asked
    initial
    begin
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go) begin
                hold_go = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic offer(input logic [CAND_BITS-1:0] cand, input logic fin);
        if (!calm && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item_valid     <= 1'b1;
        item.candidate <= cand;
        item.last      <= fin;
        do
            @(posedge clk);
        while (item_stall);
        if (cand != '0)
            sent++;
        @(negedge clk);
    endtask

    task automatic offer_run(input int unsigned start, input int unsigned step,
                             input int unsigned len, input logic closed);
        for (int unsigned k = 0; k < len; k++)
            offer(CAND_BITS'(start + k * step), closed && (k == len - 1));
    endtask

    task automatic drain_wait();
        item_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial
    begin
        int   kind;
        int   len;
        logic held;
        logic paused;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        calm       = 1'b0;
        hold_go    = 1'b0;
        sent       = 0;
        held       = 1'b0;
        paused     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero ignored, one stored blocks everything, zero with last clears
        offer(16'd0, 1'b0);
        offer(16'd1, 1'b0);
        offer(16'd7, 1'b0);
        offer(16'd0, 1'b1);
        // extremes and a descending order
        offer(16'hffff, 1'b0);
        offer(16'h8000, 1'b0);
        offer(16'd2, 1'b1);
        // fill the table, then survivors flagged full
        for (int i = 0; i < 16; i++)
            offer(CAND_BITS'(first_primes[i]), 1'b0);
        offer(16'd59, 1'b0);
        offer(16'd61, 1'b1);
        drain_wait();

        while (sent < TOTAL) begin
            if (!held && sent >= 400) begin
                hold_go = 1'b1;
                held    = 1'b1;
            end
            if (!paused && sent >= 900) begin
                drain_wait();
                paused = 1'b1;
            end
            if (sent >= CALM_FROM)
                calm = 1'b1;
            kind = $urandom_range(0, 19);
            if (kind <= 11) begin
                offer_run(2, 1, $urandom_range(1, 80), 1'b1);
            end else if (kind <= 13) begin
                offer_run($urandom_range(2, 65400), $urandom_range(1, 3),
                          $urandom_range(1, 40), 1'b1);
            end else if (kind <= 15) begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++)
                    offer(($urandom_range(0, 7) == 0) ? 16'd0
                                                      : CAND_BITS'($urandom_range(1, 65535)),
                          $urandom_range(0, 7) == 0);
            end else if (kind == 16) begin
                offer_run(2, 1, $urandom_range(1, 40), 1'b0);
            end else if (kind == 17) begin
                offer_run(1, 1, $urandom_range(1, 10), 1'b1);
            end else if (kind == 18) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    offer(16'd0, $urandom_range(0, 1));
            end else begin
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                    offer(CAND_BITS'($urandom_range(2, 200)), k == len - 1);
            end
        end

        item_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("** pipelined_prime_sieve: PASSED **");
        else
            $display("** pipelined_prime_sieve: FAILED **");
        $finish;
    end

endmodule
